// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: screen geometry defaults,
// cell layout, character codes and action codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int IDX_W   = 11;
	localparam int OROW_W  = 5;
	localparam int OCOL_W  = 7;

	localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h4F;
	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

endpackage

// ----- rtl/tcw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH  = ROWS_DEF * COLUMNS_DEF,
	parameter int ADDR_W = $clog2(ROWS_DEF * COLUMNS_DEF),
	parameter int DATA_W = CELL_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: writes characters at the cursor, handles
// newline, wrap, scroll and clear, and reads back single cells.
// ----------------------------------------------------------------------------
// After reset the block zeroes all ROWS*COLUMNS cells (2000 by default) of the
// screen store before it takes its first item. A write, newline, read or unused
// action passes from acceptance through the execute and response states to its
// result. Clearing the screen adds a pass that blanks every cell, and a scroll
// adds a pass in which the sequencer moves every cell below the top row up one
// row, with a read state and a write state for each, before it blanks the bottom
// row. One item is in work at a time; the finished result sits in an output
// register while the next is accepted.
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_color_we,
	input  logic [COLOR_W-1:0] text_color_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [IDX_W-1:0]   cell_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CELL_W-1:0]  cell_value,
	output logic [OROW_W-1:0]  cursor_row,
	output logic [OCOL_W-1:0]  cursor_col
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_ADDR   = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] BOTTOM_ADDR = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] COL_STEP    = AW'(COLUMNS);
	localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCR_RD = 3'd3;
	localparam logic [2:0] ST_SCR_WR = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_CLR    = 3'd6;
	localparam logic [2:0] ST_RESP   = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      pos_q;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [COLOR_W-1:0] color_q;
	logic [1:0]         act_q;
	logic [CHAR_W-1:0]  code_q;
	logic               in_range_q;
	logic [CELL_W-1:0]  val_q;

	logic               out_valid_q;
	logic [CELL_W-1:0]  cell_value_q;
	logic [OROW_W-1:0]  cursor_row_q;
	logic [OCOL_W-1:0]  cursor_col_q;

	logic               accept;
	logic               can_load;
	logic               ptr_last;
	logic [AW-1:0]      ptr_inc;
	logic [CELL_W-1:0]  blank_cell;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign can_load   = !out_valid_q || out_ready;
	assign ptr_last   = (ptr_q == LAST_ADDR);
	assign ptr_inc    = ptr_q + AW'(1);
	assign blank_cell = {color_q, BLANK_CODE};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = blank_cell;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re    = accept && (action == ACT_READ);
				ram_raddr = AW'(cell_index);
			end
			ST_EXEC: begin
				ram_we    = (act_q == ACT_WRITE) && (code_q != NEWLINE_CODE);
				ram_waddr = pos_q;
				ram_wdata = {color_q, code_q};
			end
			ST_SCR_RD: begin
				ram_re = 1'b1;
			end
			ST_SCR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q - COL_STEP;
				ram_wdata = ram_rdata;
			end
			ST_FILL, ST_CLR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tcw_screen_ram #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (AW),
		.DATA_W (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (text_color_we) begin
			color_q <= text_color_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action;
			code_q     <= char_code;
			in_range_q <= (32'(cell_index) < 32'(CELL_COUNT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
			pos_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			val_q   <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_inc;
					if (ptr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					val_q   <= '0;
					state_q <= ST_RESP;
					case (act_q)
						ACT_WRITE: begin
							if (code_q == NEWLINE_CODE || col_q == LAST_COL) begin
								if (row_q == LAST_ROW) begin
									ptr_q   <= COL_STEP;
									state_q <= ST_SCR_RD;
								end else begin
									row_q <= row_q + RW'(1);
									col_q <= '0;
									pos_q <= pos_q + COL_STEP - AW'(col_q);
								end
							end else begin
								col_q <= col_q + CW'(1);
								pos_q <= pos_q + AW'(1);
							end
						end
						ACT_CLEAR: begin
							ptr_q   <= '0;
							state_q <= ST_CLR;
						end
						ACT_READ: begin
							val_q <= in_range_q ? ram_rdata : '0;
						end
						default: begin
							val_q <= '0;
						end
					endcase
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					if (ptr_last) begin
						ptr_q   <= BOTTOM_ADDR;
						state_q <= ST_FILL;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= ST_SCR_RD;
					end
				end
				ST_FILL: begin
					ptr_q <= ptr_inc;
					if (ptr_last) begin
						row_q   <= LAST_ROW;
						col_q   <= '0;
						pos_q   <= BOTTOM_ADDR;
						state_q <= ST_RESP;
					end
				end
				ST_CLR: begin
					ptr_q <= ptr_inc;
					if (ptr_last) begin
						row_q   <= '0;
						col_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && can_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && can_load) begin
			cell_value_q <= val_q;
			cursor_row_q <= OROW_W'(row_q);
			cursor_col_q <= OCOL_W'(col_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

`ifndef NO_ASSERTIONS
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLUMNS)))
		else $error("cursor out of screen bounds");

	a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		(32'(pos_q) == 32'(row_q) * 32'(COLUMNS) + 32'(col_q)))
		else $error("linear cursor position out of step with row and column");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted item did not start execution");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped without acceptance");

	a_scroll_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCR_RD || state_q == ST_SCR_WR) |->
		(32'(ptr_q) >= 32'(COLUMNS)))
		else $error("scroll source pointer below second row");
`endif

endmodule

// ----- dv/tb_text_console_writer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A behavioral copy of the
// screen store, cursor and text color predicts the result of every item.
// Short directed tests cover reset contents, character extremes, newline,
// out-of-range reads, the unused action and clear. Text sessions with random
// content then drive wrap, scroll and read-back under several colors, with
// random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int COLS         = COLUMNS_DEF;
	localparam int ROWS         = ROWS_DEF;
	localparam int CELLS        = COLS * ROWS;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int MAX_SCROLLS  = 45;
	localparam int MAX_CLEARS   = 60;
	localparam int PHASE_ITEMS  = 270;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
	} console_result_t;

	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               text_color_we    = 1'b0;
	logic [COLOR_W-1:0] text_color_wdata = '0;
	logic               in_valid         = 1'b0;
	logic               in_ready;
	logic [1:0]         action           = ACT_WRITE;
	logic [CHAR_W-1:0]  char_code        = '0;
	logic [IDX_W-1:0]   cell_index       = '0;
	logic               out_valid;
	logic               out_ready        = 1'b0;
	logic [CELL_W-1:0]  cell_value;
	logic [OROW_W-1:0]  cursor_row;
	logic [OCOL_W-1:0]  cursor_col;

	logic [CELL_W-1:0]  screen_mem [CELLS];
	int unsigned        crow = 0;
	int unsigned        ccol = 0;
	logic [COLOR_W-1:0] color_reg = COLOR_RESET;
	console_result_t    pending_results [$];

	int unsigned cycle_count = 0;
	int unsigned mismatches  = 0;
	int unsigned n_writes = 0, n_newlines = 0, n_reads = 0;
	int unsigned n_clears = 0, n_scrolls = 0, n_unused = 0;
	int unsigned hold_left = 0, stall_left = 0;
	bit          tx_quiet = 1'b0, rx_quiet = 1'b0;

	text_console_writer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.text_color_we    (text_color_we),
		.text_color_wdata (text_color_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.char_code        (char_code),
		.cell_index       (cell_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.cell_value       (cell_value),
		.cursor_row       (cursor_row),
		.cursor_col       (cursor_col)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb_text_console_writer NOT OK");
			$finish;
		end
	end

	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CHAR_W-1:0] random_glyph();
		logic [CHAR_W-1:0] code;
		do
			code = CHAR_W'($urandom);
		while (code == NEWLINE_CODE);
		return code;
	endfunction

	function automatic logic [IDX_W-1:0] pick_read_index();
		int unsigned r, pos;
		r = $urandom_range(0, 9);
		pos = crow * COLS + ccol;
		if (r < 6)
			return IDX_W'((pos > 160) ? pos - $urandom_range(0, 160)
				: $urandom_range(0, pos));
		if (r < 9)
			return IDX_W'($urandom_range(0, CELLS - 1));
		return IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
	endfunction

	function automatic bit causes_scroll(logic [1:0] act, logic [CHAR_W-1:0] code);
		return act == ACT_WRITE && crow == ROWS - 1 &&
			(code == NEWLINE_CODE || ccol == COLS - 1);
	endfunction

	function automatic logic [CELL_W-1:0] colored(logic [CHAR_W-1:0] code);
		return {color_reg, code};
	endfunction

	task automatic scroll_screen();
		for (int i = 0; i < CELLS - COLS; i++)
			screen_mem[i] = screen_mem[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++)
			screen_mem[i] = colored(BLANK_CODE);
		crow = ROWS - 1;
		ccol = 0;
		n_scrolls++;
	endtask

	task automatic next_row();
		ccol = 0;
		crow++;
		if (crow >= ROWS)
			scroll_screen();
	endtask

	// Apply one accepted item to the console state and queue its result.
	task automatic console_apply(input logic [1:0] act, input logic [CHAR_W-1:0] code,
			input logic [IDX_W-1:0] idx);
		console_result_t res;
		res = '0;
		case (act)
			ACT_WRITE: begin
				if (code == NEWLINE_CODE) begin
					n_newlines++;
					next_row();
				end else begin
					n_writes++;
					screen_mem[crow * COLS + ccol] = colored(code);
					ccol++;
					if (ccol >= COLS)
						next_row();
				end
			end
			ACT_CLEAR: begin
				n_clears++;
				foreach (screen_mem[i])
					screen_mem[i] = colored(BLANK_CODE);
				crow = 0;
				ccol = 0;
			end
			ACT_READ: begin
				n_reads++;
				if (idx < CELLS)
					res.value = screen_mem[idx];
			end
			default: n_unused++;
		endcase
		res.row = crow[OROW_W-1:0];
		res.col = ccol[OCOL_W-1:0];
		pending_results.push_back(res);
	endtask

	task automatic send_item(input logic [1:0] act, input logic [CHAR_W-1:0] code,
			input logic [IDX_W-1:0] idx);
		int unsigned gap;
		gap = pick_gap(tx_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		action     = act;
		char_code  = code;
		cell_index = idx;
		do
			@(posedge clk);
		while (!in_ready);
		console_apply(act, code, idx);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_text_color(input logic [COLOR_W-1:0] color);
		wait_idle();
		@(negedge clk);
		text_color_we    = 1'b1;
		text_color_wdata = color;
		@(negedge clk);
		text_color_we = 1'b0;
		color_reg     = color;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
			if (!rx_quiet && $urandom_range(0, 3) == 0)
				stall_left = pick_gap(1'b0);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		console_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no item outstanding", $time);
			end else begin
				want = pending_results.pop_front();
				check_field("cell_value", 32'(want.value), 32'(cell_value));
				check_field("cursor_row", 32'(want.row), 32'(cursor_row));
				check_field("cursor_col", 32'(want.col), 32'(cursor_col));
			end
		end
	end

	task automatic test_reset_state();
		send_item(ACT_READ, 8'h00, 11'd0);
		send_item(ACT_READ, 8'hFF, IDX_W'(CELLS - 1));
		send_item(ACT_UNUSED, 8'hFF, 11'h7FF);
	endtask

	task automatic test_char_extremes();
		send_item(ACT_WRITE, 8'h00, 11'h7FF);
		send_item(ACT_WRITE, 8'hFF, 11'd0);
		send_item(ACT_WRITE, 8'h7F, 11'h555);
		for (int i = 0; i < 3; i++)
			send_item(ACT_READ, 8'h00, IDX_W'(i));
	endtask

	task automatic test_newline_and_range();
		send_item(ACT_WRITE, NEWLINE_CODE, 11'd0);
		send_item(ACT_READ, 8'h00, IDX_W'(CELLS));
		send_item(ACT_READ, 8'hAA, 11'h7FF);
	endtask

	task automatic test_clear_screen();
		set_text_color(8'hFF);
		send_item(ACT_CLEAR, 8'h55, 11'h2AA);
		send_item(ACT_READ, 8'h00, 11'd0);
		send_item(ACT_READ, 8'h00, IDX_W'(CELLS - 1));
		send_item(ACT_WRITE, 8'h80, 11'd0);
		send_item(ACT_READ, 8'h00, 11'd0);
	endtask

	task automatic test_wrap_and_scroll();
		int unsigned start_row, scrolls_seen;
		set_text_color(8'h00);
		start_row = crow;
		while (crow == start_row)
			send_item(ACT_WRITE, random_glyph(), IDX_W'($urandom));
		while (crow < ROWS - 1)
			send_item(ACT_WRITE, NEWLINE_CODE, IDX_W'($urandom));
		scrolls_seen = n_scrolls;
		while (n_scrolls == scrolls_seen)
			send_item(ACT_WRITE, random_glyph(), IDX_W'($urandom));
		send_item(ACT_READ, 8'h00, IDX_W'((ROWS - 2) * COLS));
		send_item(ACT_READ, 8'h00, IDX_W'(CELLS - COLS - 1));
		send_item(ACT_READ, 8'h00, IDX_W'(CELLS - 1));
		send_item(ACT_WRITE, NEWLINE_CODE, 11'd0);
		send_item(ACT_READ, 8'h00, IDX_W'((ROWS - 2) * COLS));
		send_item(ACT_READ, 8'h00, 11'd0);
	endtask

	// Hold the output while items keep coming so the input must stall.
	task automatic test_output_hold();
		tx_quiet  = 1'b1;
		hold_left = HOLD_CYCLES;
		repeat (12) send_item(ACT_WRITE, random_glyph(), IDX_W'($urandom));
		tx_quiet = 1'b0;
	endtask

	task automatic test_random_text(input logic [COLOR_W-1:0] color, input int unsigned count);
		int unsigned done, r;
		bit long_lines;
		logic [1:0] act;
		logic [CHAR_W-1:0] code;
		logic [IDX_W-1:0] idx;
		done = 0;
		long_lines = 1'b0;
		set_text_color(color);
		while (done < count) begin
			if ($urandom_range(0, 99) == 0) begin
				long_lines = ($urandom_range(0, 3) == 0);
				tx_quiet   = ($urandom_range(0, 4) == 0);
				rx_quiet   = ($urandom_range(0, 4) == 0);
			end
			r    = $urandom_range(0, 999);
			code = CHAR_W'($urandom);
			idx  = IDX_W'($urandom);
			if (r < 3) begin
				act = ACT_CLEAR;
			end else if (r < 25) begin
				act = ACT_UNUSED;
			end else if (r < 200) begin
				act = ACT_READ;
				idx = pick_read_index();
			end else begin
				act  = ACT_WRITE;
				code = ($urandom_range(0, long_lines ? 199 : 7) == 0) ? NEWLINE_CODE
					: random_glyph();
			end
			if (act == ACT_CLEAR && n_clears >= MAX_CLEARS)
				act = ACT_READ;
			// Cap the slow scrolls; home the cursor with a clear instead, or read if clears are capped.
			if (causes_scroll(act, code) && n_scrolls >= MAX_SCROLLS)
				act = (n_clears < MAX_CLEARS) ? ACT_CLEAR : ACT_READ;
			if (act != ACT_UNUSED)
				done++;
			send_item(act, code, idx);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		foreach (screen_mem[i])
			screen_mem[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_char_extremes();
		test_newline_and_range();
		test_clear_screen();
		test_wrap_and_scroll();
		test_output_hold();
		test_random_text(8'hFF, PHASE_ITEMS);
		test_random_text(8'h00, PHASE_ITEMS);
		test_random_text(COLOR_W'($urandom), PHASE_ITEMS);
		test_random_text(COLOR_RESET, PHASE_ITEMS);
		test_random_text(COLOR_W'($urandom), PHASE_ITEMS);
		test_random_text(COLOR_W'($urandom), PHASE_ITEMS);
		wait_idle();
		$display("covered %0d characters, %0d newlines, %0d reads, %0d clears, %0d unused",
			n_writes, n_newlines, n_reads, n_clears, n_unused);
		$display("with %0d scrolls in %0d cycles, %0d mismatches", n_scrolls, cycle_count,
			mismatches);
		if (mismatches == 0)
			$display("tb_text_console_writer OK");
		else
			$display("tb_text_console_writer NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer.sv
dv/tb_text_console_writer.sv
